### rtl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### rtl/dtfs_pkg.sv
// Types and constants for the delimited text field splitter.
`timescale 1ns / 1ps

package dtfs_pkg;

	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_FEND = 2'd1;
	localparam logic [1:0] KIND_EOI  = 2'd2;

	localparam logic [1:0] REG_FIELD_COUNT = 2'd0;
	localparam logic [1:0] REG_DELIMITER   = 2'd1;
	localparam logic [1:0] REG_SKIP_LINES  = 2'd2;

	localparam logic [15:0] LEN_MAX = 16'hFFFF;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data;
		logic [23:0] obs;
		logic [7:0]  vidx;
		logic [15:0] len;
		logic        last;
	} result_t;

	function automatic result_t make_res(input logic [1:0] kind, input logic [7:0] data,
		input logic [23:0] obs, input logic [7:0] vidx, input logic [15:0] len,
		input logic last);
		result_t r;
		r.kind = kind;
		r.data = data;
		r.obs  = obs;
		r.vidx = vidx;
		r.len  = len;
		r.last = last;
		return r;
	endfunction

endpackage

### rtl/delimited_text_field_splitter.sv
// Top level of the delimited text field splitter.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Splits a byte stream of delimited text into fields.
// Input channel s_axis: one text byte per item in tdata; tuser[0] high marks
// end of input (tdata ignored). Output channel m_axis: one result per item,
// tuser = kind (content byte, field end, end of input), tdata = byte, record
// index, field index and field length; tlast flags the last result that a
// given input item produced.
// Config port: cfg_we/cfg_addr/cfg_wdata; the user writes it only while the block is idle,
// which the block itself does not enforce; a write to skip_lines also reloads the header line counter.
// Timing: an accepted item is held in the input register, then is resolved
// combinationally and written into a two-entry result buffer once it has
// room; its first result is offered on m_axis from the head of that buffer.
// One item per cycle is taken as long as results drain; an item that yields
// two results (held CR plus a new byte) sends them one after the other
// through the single output port.
// A stalled receiver fills the result buffer, then the input register holds
// and s_axis_tready drops; nothing is lost or repeated.
// Reset clears counters, the held CR, the buffer and loads the register
// defaults (one field, comma, no header lines).
module delimited_text_field_splitter #(
	parameter int MAX_FIELDS = 256,
	parameter int OBS_BITS   = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	input  logic [0:0]  s_axis_tuser,   // [0] is_end
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,   // [7:0] out_byte, [31:8] rec_index,
	                                    // [39:32] fld_index, [55:40] fld_length
	output logic [1:0]  m_axis_tuser,   // [1:0] kind
	output logic        m_axis_tlast,   // last
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [15:0] cfg_wdata
);

	localparam int VARW = (MAX_FIELDS > 2) ? $clog2(MAX_FIELDS) : 1;
	localparam int CMPW = ((VARW > 9) ? VARW : 9) + 1;
	localparam logic [CMPW-1:0] MAXF = CMPW'(MAX_FIELDS);

	// configuration
	logic [8:0]  field_count_q;
	logic [7:0]  delim_q;
	logic [15:0] skip_lines_q;

	// parse state
	logic [15:0]       lines_to_skip_q, lines_to_skip_d;
	logic [VARW-1:0]   cur_var_q, cur_var_d;
	logic [OBS_BITS-1:0] cur_obs_q, cur_obs_d;
	logic [15:0]       cur_len_q, cur_len_d;
	logic              cr_pend_q, cr_pend_d;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;

	// result buffer, slot 0 is the head
	dtfs_pkg::result_t buf0_q, buf1_q, nb0, nb1;
	logic [1:0] cnt_q, cnt_d, cnt_pop;
	logic       pop, commit;

	// per-item results
	dtfs_pkg::result_t r0, r1;
	logic [1:0] nres;

	logic [CMPW-1:0] fc_ext, n_eff;
	logic            is_last;
	logic [7:0]      term;
	logic [23:0]     obs_o;
	logic [7:0]      var_o;
	logic [16:0]     len_sum;

	always_comb begin
		fc_ext = CMPW'(field_count_q);
		if (field_count_q == 9'd0) begin
			n_eff = CMPW'(1);
		end else if (fc_ext > MAXF) begin
			n_eff = MAXF;
		end else begin
			n_eff = fc_ext;
		end
		is_last = (CMPW'(cur_var_q) + CMPW'(1)) >= n_eff;
		term    = is_last ? dtfs_pkg::CH_LF : delim_q;
		obs_o   = 24'(cur_obs_q);
		var_o   = 8'(cur_var_q);
	end

	// resolve the item in the input register
	always_comb begin
		r0 = '0;
		r1 = '0;
		nres = 2'd0;
		lines_to_skip_d = lines_to_skip_q;
		cur_var_d = cur_var_q;
		cur_obs_d = cur_obs_q;
		cur_len_d = cur_len_q;
		cr_pend_d = cr_pend_q;
		len_sum   = '0;
		if (end_s1) begin
			// flush a held CR, then the end marker; then restart
			if (cr_pend_q) begin
				r0 = dtfs_pkg::make_res(dtfs_pkg::KIND_DATA, dtfs_pkg::CH_CR, obs_o, var_o,
					16'd0, 1'b0);
				r1 = dtfs_pkg::make_res(dtfs_pkg::KIND_EOI, 8'd0, obs_o, var_o, 16'd0, 1'b1);
				nres = 2'd2;
			end else begin
				r0 = dtfs_pkg::make_res(dtfs_pkg::KIND_EOI, 8'd0, obs_o, var_o, 16'd0, 1'b1);
				nres = 2'd1;
			end
			lines_to_skip_d = skip_lines_q;
			cur_var_d = '0;
			cur_obs_d = '0;
			cur_len_d = '0;
			cr_pend_d = 1'b0;
		end else if (lines_to_skip_q != 16'd0) begin
			// header line: drop the byte
			if (byte_s1 == dtfs_pkg::CH_LF) begin
				lines_to_skip_d = lines_to_skip_q - 16'd1;
			end
		end else if (byte_s1 == term) begin
			// field end; a held CR is swallowed
			r0 = dtfs_pkg::make_res(dtfs_pkg::KIND_FEND, 8'd0, obs_o, var_o, cur_len_q, 1'b1);
			nres = 2'd1;
			cr_pend_d = 1'b0;
			cur_len_d = '0;
			if (is_last) begin
				cur_var_d = '0;
				if (cur_obs_q != {OBS_BITS{1'b1}}) begin
					cur_obs_d = cur_obs_q + OBS_BITS'(1);
				end
			end else begin
				cur_var_d = cur_var_q + VARW'(1);
			end
		end else begin
			// content; a CR is held one byte in case a terminator follows
			cr_pend_d = (byte_s1 == dtfs_pkg::CH_CR);
			if (cr_pend_q) begin
				r0 = dtfs_pkg::make_res(dtfs_pkg::KIND_DATA, dtfs_pkg::CH_CR, obs_o, var_o,
					16'd0, byte_s1 == dtfs_pkg::CH_CR);
				if (byte_s1 != dtfs_pkg::CH_CR) begin
					r1 = dtfs_pkg::make_res(dtfs_pkg::KIND_DATA, byte_s1, obs_o, var_o,
						16'd0, 1'b1);
					nres = 2'd2;
				end else begin
					nres = 2'd1;
				end
			end else if (byte_s1 != dtfs_pkg::CH_CR) begin
				r0 = dtfs_pkg::make_res(dtfs_pkg::KIND_DATA, byte_s1, obs_o, var_o, 16'd0, 1'b1);
				nres = 2'd1;
			end
			len_sum = {1'b0, cur_len_q} + 17'(nres);
			cur_len_d = len_sum[16] ? dtfs_pkg::LEN_MAX : len_sum[15:0];
		end
	end

	// handshake and result buffer
	assign pop     = (cnt_q != 2'd0) && m_axis_tready;
	assign cnt_pop = cnt_q - {1'b0, pop};
	assign commit  = valid_s1 && (({1'b0, cnt_pop} + {1'b0, nres}) <= 3'd2);
	assign s_axis_tready = !valid_s1 || commit;

	always_comb begin
		nb0 = pop ? buf1_q : buf0_q;
		nb1 = buf1_q;
		cnt_d = cnt_pop;
		if (commit) begin
			cnt_d = cnt_pop + nres;
			if (cnt_pop == 2'd0) begin
				nb0 = r0;
				nb1 = r1;
			end else if (cnt_pop == 2'd1) begin
				nb1 = r0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cnt_q <= 2'd0;
			field_count_q <= 9'd1;
			delim_q <= 8'd44;
			skip_lines_q <= 16'd0;
			lines_to_skip_q <= 16'd0;
			cur_var_q <= '0;
			cur_obs_q <= '0;
			cur_len_q <= '0;
			cr_pend_q <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			cnt_q <= cnt_d;
			if (commit) begin
				lines_to_skip_q <= lines_to_skip_d;
				cur_var_q <= cur_var_d;
				cur_obs_q <= cur_obs_d;
				cur_len_q <= cur_len_d;
				cr_pend_q <= cr_pend_d;
			end
			if (cfg_we) begin
				case (cfg_addr)
					dtfs_pkg::REG_FIELD_COUNT: begin
						field_count_q <= cfg_wdata[8:0];
					end
					dtfs_pkg::REG_DELIMITER: begin
						delim_q <= cfg_wdata[7:0];
					end
					dtfs_pkg::REG_SKIP_LINES: begin
						skip_lines_q <= cfg_wdata;
						lines_to_skip_q <= cfg_wdata;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			end_s1 <= s_axis_tuser[0];
		end
		buf0_q <= nb0;
		buf1_q <= nb1;
	end

	assign m_axis_tvalid = (cnt_q != 2'd0);
	assign m_axis_tuser  = buf0_q.kind;
	assign m_axis_tlast  = buf0_q.last;
	assign m_axis_tdata  = {buf0_q.len, buf0_q.vidx, buf0_q.obs, buf0_q.data};

	// result buffer never holds more than its two slots
	`ASSERT_SAME(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= 2'd2)
	// input stalls only while an item waits for buffer space
	`ASSERT_SAME(a_stall_reason, clk, arst_n, !s_axis_tready, valid_s1)
	// end of input restarts the parse state
	`ASSERT_NEXT(a_end_restart, clk, arst_n, commit && end_s1,
		cur_var_q == '0 && cur_obs_q == '0 && cur_len_q == '0 && !cr_pend_q)

endmodule
